// ----- design/time_window_bucket_manager_assert.svh -----
// Assertion macros for the time window bucket manager.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TIME_WINDOW_BUCKET_MANAGER_ASSERT_SVH
`define TIME_WINDOW_BUCKET_MANAGER_ASSERT_SVH

// same-cycle implication
`define TWBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/twbm_pkg.sv -----
// Shared types and constants of the time window bucket manager.
// No dependencies; used by every module of the block.
`default_nettype none
package twbm_pkg;

    localparam int TIME_W  = 48;
    localparam int BOUND_W = 49;
    localparam int ID_W    = 16;
    localparam int DROP_W  = 5;
    localparam int IDX_CFG_W = 2;

    localparam logic [TIME_W-1:0] IV_RESET = 48'd3600;

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_MERGE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_STALE     = 3'd2;
    localparam logic [2:0] ST_CORRUPT   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [IDX_CFG_W-1:0] REG_TTL = 2'd0;
    localparam logic [IDX_CFG_W-1:0] REG_IV  = 2'd1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] key_time;
        logic [TIME_W-1:0] cur_time;
        logic              key_bad;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [ID_W-1:0]    window_id;
        logic [BOUND_W-1:0] window_bound;
        logic               created;
        logic [DROP_W-1:0]  dropped;
    } rsp_t;

    typedef struct packed {
        logic       latch;
        logic       rd_head;
        logic       rd_ptr;
        logic       pop;
        logic       ptr_from_head;
        logic       step;
        logic       load_hit;
        logic       bound_direct;
        logic       div_start;
        logic       bound_div;
        logic       create;
        logic       out_load;
        logic [2:0] st;
    } ctl_t;

    typedef struct packed {
        logic       req_bad;
        logic [1:0] cmd;
        logic       count_zero;
        logic       count_full;
        logic       drop_hit;
        logic       stale;
        logic       look_hit;
        logic       look_end;
        logic       below_latest;
        logic       div_done;
        logic       out_free;
    } dps_t;

endpackage
`default_nettype wire

// ----- design/twbm_div.sv -----
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on twbm_pkg for widths.
`default_nettype none
module twbm_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [twbm_pkg::TIME_W-1:0] dividend,
    input  wire logic [twbm_pkg::TIME_W-1:0] divisor,
    output logic                             done,
    output logic [twbm_pkg::TIME_W-1:0]      rem
);
    localparam int CW = $clog2(twbm_pkg::TIME_W + 1);

    logic                        busy_reg, busy_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [twbm_pkg::TIME_W-1:0] dvd_reg, dvd_next;
    logic [twbm_pkg::TIME_W-1:0] rem_reg, rem_next;
    logic [twbm_pkg::TIME_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[twbm_pkg::TIME_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(twbm_pkg::TIME_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = twbm_pkg::TIME_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[twbm_pkg::TIME_W-1:0];
            dvd_next = {dvd_reg[twbm_pkg::TIME_W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// ----- design/twbm_ctrl.sv -----
// Controller state machine: sequences retirement, lookup, creation and response.
// Depends on twbm_pkg for command and status structs.
`default_nettype none
module twbm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire twbm_pkg::dps_t  dps,
    output twbm_pkg::ctl_t       ctl
);
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DROP_RD  = 10'b00_0000_0010,
        S_DROP_CHK = 10'b00_0000_0100,
        S_STALE    = 10'b00_0000_1000,
        S_LOOK_RD  = 10'b00_0001_0000,
        S_LOOK_CHK = 10'b00_0010_0000,
        S_MISS     = 10'b00_0100_0000,
        S_DIV      = 10'b00_1000_0000,
        S_CREATE   = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        ctl        = '0;
        ctl.st     = st_reg;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DROP_RD;
                end
            end
            S_DROP_RD:
            begin
                if (dps.req_bad)
                begin
                    st_next    = twbm_pkg::ST_CORRUPT;
                    state_next = S_RESP;
                end
                else if ((dps.cmd == twbm_pkg::CMD_GET) || (dps.cmd == twbm_pkg::CMD_MERGE)
                         || dps.count_zero)
                begin
                    state_next = S_STALE;
                end
                else
                begin
                    ctl.rd_head = 1'b1;
                    state_next  = S_DROP_CHK;
                end
            end
            S_DROP_CHK:
            begin
                if (dps.drop_hit)
                begin
                    ctl.pop    = 1'b1;
                    state_next = S_DROP_RD;
                end
                else
                    state_next = S_STALE;
            end
            S_STALE:
            begin
                if ((dps.cmd != twbm_pkg::CMD_MERGE) && dps.stale)
                begin
                    st_next    = (dps.cmd == twbm_pkg::CMD_PUT) ? twbm_pkg::ST_STALE
                                                                : twbm_pkg::ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.ptr_from_head = 1'b1;
                    state_next        = S_LOOK_RD;
                end
            end
            S_LOOK_RD:
            begin
                if (dps.look_end)
                    state_next = S_MISS;
                else
                begin
                    ctl.rd_ptr = 1'b1;
                    state_next = S_LOOK_CHK;
                end
            end
            S_LOOK_CHK:
            begin
                if (dps.look_hit)
                begin
                    ctl.load_hit = 1'b1;
                    st_next      = twbm_pkg::ST_OK;
                    state_next   = S_RESP;
                end
                else
                begin
                    ctl.step   = 1'b1;
                    state_next = S_LOOK_RD;
                end
            end
            S_MISS:
            begin
                if ((dps.cmd == twbm_pkg::CMD_GET) || (dps.cmd == twbm_pkg::CMD_DELETE))
                begin
                    st_next    = twbm_pkg::ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else if (dps.count_full)
                begin
                    st_next    = twbm_pkg::ST_FULL;
                    state_next = S_RESP;
                end
                else if (dps.count_zero || dps.below_latest)
                begin
                    ctl.bound_direct = 1'b1;
                    state_next       = S_CREATE;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (dps.div_done)
                begin
                    ctl.bound_div = 1'b1;
                    state_next    = S_CREATE;
                end
            end
            S_CREATE:
            begin
                ctl.create = 1'b1;
                st_next    = twbm_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (dps.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= twbm_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end
endmodule
`default_nettype wire

// ----- design/twbm_dp.sv -----
// Datapath: configuration, window ring memory, ring pointers, result register.
// Depends on twbm_pkg and twbm_div.
`default_nettype none
module twbm_dp #(
    parameter int WINDOWS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire twbm_pkg::req_t                 req,
    input  wire logic                           cfg_we,
    input  wire logic [twbm_pkg::IDX_CFG_W-1:0] cfg_index,
    input  wire logic [twbm_pkg::TIME_W-1:0]    cfg_data,
    input  wire twbm_pkg::ctl_t                 ctl,
    output twbm_pkg::dps_t                      dps,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output twbm_pkg::rsp_t                      rsp
);
    localparam int IDX_W = $clog2(WINDOWS);
    localparam int CNT_W = $clog2(WINDOWS + 1);
    localparam int TW    = twbm_pkg::TIME_W;
    localparam int BW    = twbm_pkg::BOUND_W;
    localparam int IW    = twbm_pkg::ID_W;
    localparam int DW    = twbm_pkg::DROP_W;

    logic [TW-1:0]    ttl_reg, iv_reg;
    twbm_pkg::req_t   req_reg;
    logic [IDX_W-1:0] head_reg, ptr_reg;
    logic [CNT_W-1:0] count_reg, idx_reg;
    logic [BW-1:0]    latest_reg;
    logic [IW-1:0]    next_id_reg;
    logic [DW-1:0]    dropped_reg;
    logic [IW-1:0]    res_id_reg;
    logic [BW-1:0]    res_bound_reg;
    logic             res_created_reg;
    logic [BW-1:0]    bound_reg;
    logic [BW-1:0]    rd_bound_reg;
    logic [IW-1:0]    rd_id_reg;
    logic             out_valid_reg;
    twbm_pkg::rsp_t   rsp_reg;

    logic [BW-1:0]    mem_bound [WINDOWS];
    logic [IW-1:0]    mem_id    [WINDOWS];

    logic [TW-1:0]    iv;
    logic [IDX_W-1:0] rd_addr;
    logic             div_done;
    logic [TW-1:0]    div_rem;
    logic [TW-1:0]    div_dvd;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        if (x == IDX_W'(WINDOWS - 1))
            r = '0;
        else
            r = x + IDX_W'(1);
        return r;
    endfunction

    assign iv      = (iv_reg == '0) ? TW'(1) : iv_reg;
    assign rd_addr = ctl.rd_head ? head_reg : ptr_reg;
    assign div_dvd = req_reg.cur_time - latest_reg[TW-1:0];

    twbm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dvd),
        .divisor  (iv),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        dps.req_bad      = req_reg.key_bad;
        dps.cmd          = req_reg.cmd;
        dps.count_zero   = (count_reg == '0);
        dps.count_full   = (count_reg == CNT_W'(WINDOWS));
        dps.drop_hit     = ({1'b0, rd_bound_reg} + {2'b0, ttl_reg}) <= {2'b0, req_reg.cur_time};
        dps.stale        = (ttl_reg != '0) &&
                           ({1'b0, req_reg.cur_time} >= ({1'b0, req_reg.key_time} + {1'b0, ttl_reg}));
        dps.look_hit     = rd_bound_reg > {1'b0, req_reg.key_time};
        dps.look_end     = (idx_reg == count_reg);
        dps.below_latest = {1'b0, req_reg.cur_time} < latest_reg;
        dps.div_done     = div_done;
        dps.out_free     = !out_valid_reg || rsp_ready;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.create)
        begin
            mem_bound[ptr_reg] <= bound_reg;
            mem_id[ptr_reg]    <= next_id_reg;
        end
        if (ctl.rd_head || ctl.rd_ptr)
        begin
            rd_bound_reg <= mem_bound[rd_addr];
            rd_id_reg    <= mem_id[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
            req_reg <= req;
        if (ctl.bound_direct)
        begin
            if (count_reg == '0)
                bound_reg <= {1'b0, req_reg.cur_time} + {1'b0, iv};
            else
                bound_reg <= BW'({1'b0, latest_reg} + {2'b0, iv});
        end
        else if (ctl.bound_div)
            bound_reg <= {1'b0, req_reg.cur_time} + {1'b0, iv} - {1'b0, div_rem};
        if (ctl.ptr_from_head)
            ptr_reg <= head_reg;
        else if (ctl.step)
            ptr_reg <= wrap_inc(ptr_reg);
        if (ctl.out_load)
        begin
            rsp_reg.status  <= ctl.st;
            rsp_reg.dropped <= dropped_reg;
            if (ctl.st == twbm_pkg::ST_OK)
            begin
                rsp_reg.window_id    <= res_id_reg;
                rsp_reg.window_bound <= res_bound_reg;
                rsp_reg.created      <= res_created_reg;
            end
            else
            begin
                rsp_reg.window_id    <= '0;
                rsp_reg.window_bound <= '0;
                rsp_reg.created      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg         <= '0;
            iv_reg          <= twbm_pkg::IV_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            latest_reg      <= '0;
            next_id_reg     <= '0;
            dropped_reg     <= '0;
            res_id_reg      <= '0;
            res_bound_reg   <= '0;
            res_created_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    twbm_pkg::REG_TTL: ttl_reg <= cfg_data;
                    twbm_pkg::REG_IV:  iv_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (ctl.latch)
            begin
                dropped_reg     <= '0;
                res_id_reg      <= '0;
                res_bound_reg   <= '0;
                res_created_reg <= 1'b0;
            end
            if (ctl.pop)
            begin
                head_reg    <= wrap_inc(head_reg);
                count_reg   <= count_reg - CNT_W'(1);
                dropped_reg <= dropped_reg + DW'(1);
            end
            if (ctl.ptr_from_head)
                idx_reg <= '0;
            else if (ctl.step)
                idx_reg <= idx_reg + CNT_W'(1);
            if (ctl.load_hit)
            begin
                res_id_reg    <= rd_id_reg;
                res_bound_reg <= rd_bound_reg;
            end
            if (ctl.create)
            begin
                count_reg       <= count_reg + CNT_W'(1);
                latest_reg      <= bound_reg;
                next_id_reg     <= next_id_reg + IW'(1);
                res_id_reg      <= next_id_reg;
                res_bound_reg   <= bound_reg;
                res_created_reg <= 1'b1;
            end
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;
endmodule
`default_nettype wire

// ----- design/time_window_bucket_manager.sv -----
// Top level of the time window bucket manager: controller plus datapath.
// Depends on twbm_pkg, twbm_ctrl, twbm_dp and the assertion macro header.
//
// Usage:
//   req (valid/ready) carries one request; rsp (valid/ready) returns one result.
//   cfg_we writes ttl (index 0) or window_interval (index 1) from cfg_data;
//   write only while no request is in flight. Other indexes are ignored.
//   One request is worked at a time; req_ready is high only when idle.
//   From transfer to rsp_valid a request passes dispatch, the stale check
//   and the response; put and delete add a head read and check per window
//   dropped and one for a head that is kept, and each ring entry compared
//   is read and checked. A miss adds the end of scan and a decision, a new
//   window its creation, and a division, one bit per cycle, when the bound
//   needs the remainder of (cur_time - latest) by window_interval. A new
//   request can be taken in the cycle after the result is loaded.
//   The result waits in an output register; a new request is taken while
//   it is held, and a stalled receiver holds the next result in the
//   controller until the register frees.
//   Reset empties the ring, zeroes next id and latest bound, restores
//   ttl to 0 and window_interval to 3600. The ring memory is not cleared.
`default_nettype none
`include "time_window_bucket_manager_assert.svh"
module time_window_bucket_manager #(
    parameter int WINDOWS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire twbm_pkg::req_t                 req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output twbm_pkg::rsp_t                      rsp,
    input  wire logic                           cfg_we,
    input  wire logic [twbm_pkg::IDX_CFG_W-1:0] cfg_index,
    input  wire logic [twbm_pkg::TIME_W-1:0]    cfg_data
);
    twbm_pkg::ctl_t ctl;
    twbm_pkg::dps_t dps;

    twbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .dps       (dps),
        .ctl       (ctl)
    );

    twbm_dp #(
        .WINDOWS (WINDOWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .dps       (dps),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `TWBM_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
    `TWBM_ASSERT_IMP(a_no_overfill, ctl.create, !dps.count_full, "window created in full ring")
    `TWBM_ASSERT_IMP(a_out_free, ctl.out_load, dps.out_free, "result overwrote pending result")
endmodule
`default_nettype wire
